>>> sv/asba_pkg.sv
// asba_pkg: request, result, command and status types for the skyline allocator
// no dependencies; imported by every module of the block

package asba_pkg;

    typedef struct packed {
        logic [7:0] rect_width;
        logic [7:0] rect_height;
    } t_req;

    typedef struct packed {
        logic [5:0] page_index;
        logic [6:0] col_pos;
        logic [6:0] row_pos;
        logic       all_full;
    } t_res;

    typedef struct packed {
        logic load;
        logic clr;
        logic p1_init;
        logic p1_rd;
        logic p2_init;
        logic p2_rd;
        logic pg_next;
        logic wr_init;
        logic wr;
        logic emit_place;
        logic emit_full;
        logic emit_origin;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic w_zero;
        logic w_wide;
        logic h_fit0;
        logic x_zero;
        logic x_end;
        logic fits;
        logic pg_last;
        logic wr_last;
    } t_sts;

endpackage

>>> sv/asba_ctrl.sv
// asba_ctrl: sequencing state machine of the skyline allocator
// depends on asba_pkg (command and status types); drives asba_dpath

module asba_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  asba_pkg::t_sts i_sts,
    output asba_pkg::t_cmd o_cmd,
    output logic           busy,
    output logic           o_done
);
    import asba_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CLR  = 4'd1;
    localparam logic [3:0] S_CHK  = 4'd2;
    localparam logic [3:0] S_P1   = 4'd3;
    localparam logic [3:0] S_P1D  = 4'd4;
    localparam logic [3:0] S_P2   = 4'd5;
    localparam logic [3:0] S_P2D  = 4'd6;
    localparam logic [3:0] S_DEC  = 4'd7;
    localparam logic [3:0] S_WR   = 4'd8;

    logic [3:0] r_state, n_state;
    logic       r_done, n_done;
    t_cmd       cmd;

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        cmd     = '0;
        case (r_state)
            S_CLR: begin
                cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    cmd.load = 1'b1;
                    n_state  = S_CHK;
                end
            end
            S_CHK: begin
                if (i_sts.w_zero) begin
                    cmd.emit_origin = i_sts.h_fit0;
                    cmd.emit_full   = !i_sts.h_fit0;
                    n_done          = 1'b1;
                    n_state         = S_IDLE;
                end else if (i_sts.w_wide) begin
                    cmd.emit_full = 1'b1;
                    n_done        = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    cmd.p1_init = 1'b1;
                    n_state     = S_P1;
                end
            end
            S_P1: begin
                cmd.p1_rd = 1'b1;
                if (i_sts.x_zero) begin
                    n_state = S_P1D;
                end
            end
            S_P1D: begin
                cmd.p2_init = 1'b1;
                n_state     = S_P2;
            end
            S_P2: begin
                cmd.p2_rd = 1'b1;
                if (i_sts.x_end) begin
                    n_state = S_P2D;
                end
            end
            S_P2D: begin
                n_state = S_DEC;
            end
            S_DEC: begin
                if (i_sts.fits) begin
                    cmd.wr_init = 1'b1;
                    n_state     = S_WR;
                end else if (i_sts.pg_last) begin
                    cmd.emit_full = 1'b1;
                    n_done        = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    cmd.pg_next = 1'b1;
                    cmd.p1_init = 1'b1;
                    n_state     = S_P1;
                end
            end
            S_WR: begin
                cmd.wr = 1'b1;
                if (i_sts.wr_last) begin
                    cmd.emit_place = 1'b1;
                    n_done         = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    assign o_cmd  = cmd;
    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;

`ifndef ASSERT_OFF
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("result strobe on two cycles in a row");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == S_IDLE))
        else $error("result strobe while still working");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && r_state == S_CHK))
        else $error("accepted beat did not start a request");
    a_clr_only_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_CLR) |=> (r_state != S_CLR))
        else $error("clearing pass re-entered outside reset");
`endif

endmodule

>>> sv/asba_dpath.sv
// asba_dpath: column height store, block max scratch, window search and write-back
// depends on asba_pkg (command, status, request and result types)

module asba_dpath #(
    parameter int PAGE_WIDTH  = 128,
    parameter int PAGE_HEIGHT = 128,
    parameter int NUM_PAGES   = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  asba_pkg::t_req i_req,
    input  asba_pkg::t_cmd i_cmd,
    output asba_pkg::t_sts o_sts,
    output asba_pkg::t_res o_res
);
    import asba_pkg::*;

    localparam int CW    = $clog2(PAGE_WIDTH);
    localparam int SW    = $clog2(PAGE_HEIGHT + 1);
    localparam int SUMW  = ((SW > 8) ? SW : 8) + 1;
    localparam int CMPW  = ((CW > 8) ? CW : 8) + 1;
    localparam int PGW   = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int DEPTH = NUM_PAGES * PAGE_WIDTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [CW-1:0]   XLAST = CW'(PAGE_WIDTH - 1);
    localparam logic [CW-1:0]   XEND  = CW'(PAGE_WIDTH - 2);
    localparam logic [SW-1:0]   HMAX  = SW'(PAGE_HEIGHT);
    localparam logic [SUMW-1:0] HLIM  = SUMW'(PAGE_HEIGHT);
    localparam logic [CMPW-1:0] WLIM  = CMPW'(PAGE_WIDTH);
    localparam logic [AW-1:0]   PSTEP = AW'(PAGE_WIDTH);
    localparam logic [AW-1:0]   ALAST = AW'(DEPTH - 1);
    localparam logic [PGW-1:0]  PLAST = PGW'(NUM_PAGES - 1);

    // storage
    logic [SW-1:0] r_col_mem [DEPTH];
    logic [SW:0]   r_scr_mem [PAGE_WIDTH];
    logic [SW-1:0] r_col_rd;
    logic [SW:0]   r_scr_a, r_scr_b;

    // request and search registers
    logic [7:0]     r_w, r_h;
    logic [AW-1:0]  r_base, r_clr;
    logic [PGW-1:0] r_page;
    logic [CW-1:0]  r_x, r_bx;
    logic [7:0]     r_k;
    logic [SW-1:0]  r_best, r_suf, r_pre;
    logic           r_found;
    t_res           r_res;

    // read pipe tags
    logic           r_p1v, r_p2v;
    logic [CW-1:0]  r_p1x, r_p2x;
    logic           r_p1_re, r_p1_le, r_p2_cand;

    logic [CMPW-1:0] w_ext, x_ext, wm1;
    logic [CMPW-1:0] xb_ext;
    logic [CW-1:0]   xb;
    logic            cand;
    logic [AW-1:0]   rd_addr, wr_addr;
    logic [SW-1:0]   new_h;
    logic [SUMW-1:0] sum;
    logic [SW-1:0]   n_suf, n_pre, top, suf_b;

    assign w_ext  = CMPW'(r_w);
    assign x_ext  = CMPW'(r_x);
    assign wm1    = w_ext - CMPW'(1);
    assign cand   = (x_ext >= wm1);
    assign xb_ext = x_ext - wm1;
    assign xb     = cand ? xb_ext[CW-1:0] : '0;
    assign rd_addr = r_base + AW'(r_x);
    assign wr_addr = r_base + AW'(r_bx) + AW'(r_x);
    assign sum     = SUMW'(r_best) + SUMW'(r_h);
    assign new_h   = sum[SW-1:0];

    // block suffix max, right to left
    assign n_suf = (r_p1_re || r_col_rd > r_suf) ? r_col_rd : r_suf;
    // block prefix max, left to right
    assign n_pre = (r_scr_a[SW] || r_p2x == '0 || r_col_rd > r_pre) ? r_col_rd : r_pre;
    assign suf_b = r_scr_b[SW-1:0];
    assign top   = (suf_b > n_pre) ? suf_b : n_pre;

    // memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            r_col_mem[r_clr] <= '0;
        end else if (i_cmd.wr) begin
            r_col_mem[wr_addr] <= new_h;
        end
        r_col_rd <= r_col_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (r_p1v) begin
            r_scr_mem[r_p1x] <= {r_p1_le, n_suf};
        end
        r_scr_a <= r_scr_mem[r_x];
        r_scr_b <= r_scr_mem[xb];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
            r_p1v <= 1'b0;
            r_p2v <= 1'b0;
        end else begin
            if (i_cmd.clr) begin
                r_clr <= r_clr + AW'(1);
            end
            r_p1v <= i_cmd.p1_rd;
            r_p2v <= i_cmd.p2_rd;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_w    <= i_req.rect_width;
            r_h    <= i_req.rect_height;
            r_base <= '0;
            r_page <= '0;
        end else if (i_cmd.pg_next) begin
            r_base <= r_base + PSTEP;
            r_page <= r_page + PGW'(1);
        end

        if (i_cmd.p1_init) begin
            r_x <= XLAST;
            r_k <= '0;
        end else if (i_cmd.p1_rd) begin
            r_x <= r_x - CW'(1);
            r_k <= (r_k == wm1[7:0]) ? 8'd0 : r_k + 8'd1;
        end else if (i_cmd.p2_init || i_cmd.wr_init) begin
            r_x <= '0;
        end else if (i_cmd.p2_rd || i_cmd.wr) begin
            r_x <= r_x + CW'(1);
        end

        r_p1x     <= r_x;
        r_p1_re   <= (r_k == 8'd0);
        r_p1_le   <= (r_k == wm1[7:0]);
        r_p2x     <= r_x;
        r_p2_cand <= cand;

        if (r_p1v) begin
            r_suf <= n_suf;
        end
        if (r_p2v) begin
            r_pre <= n_pre;
        end

        if (i_cmd.p2_init) begin
            r_best  <= HMAX;
            r_found <= 1'b0;
            r_bx    <= '0;
        end else if (r_p2v && r_p2_cand && top < r_best) begin
            r_best  <= top;
            r_found <= 1'b1;
            r_bx    <= r_p2x - wm1[CW-1:0];
        end

        if (i_cmd.emit_place) begin
            r_res.page_index <= 6'(r_page);
            r_res.col_pos    <= 7'(r_bx);
            r_res.row_pos    <= 7'(r_best);
            r_res.all_full   <= 1'b0;
        end else if (i_cmd.emit_full) begin
            r_res.page_index <= '0;
            r_res.col_pos    <= '0;
            r_res.row_pos    <= '0;
            r_res.all_full   <= 1'b1;
        end else if (i_cmd.emit_origin) begin
            r_res <= '0;
        end
    end

    always_comb begin
        o_sts          = '0;
        o_sts.clr_last = (r_clr == ALAST);
        o_sts.w_zero   = (r_w == 8'd0);
        o_sts.w_wide   = (w_ext >= WLIM);
        o_sts.h_fit0   = (SUMW'(r_h) <= HLIM);
        o_sts.x_zero   = (r_x == '0);
        o_sts.x_end    = (r_x == XEND);
        o_sts.fits     = r_found && (sum <= HLIM);
        o_sts.pg_last  = (r_page == PLAST);
        o_sts.wr_last  = (x_ext == wm1);
    end

    assign o_res = r_res;

endmodule

>>> sv/atlas_skyline_block_allocator.sv
// atlas_skyline_block_allocator: top level of the skyline page allocator
// depends on asba_pkg, asba_ctrl and asba_dpath
//
//   channel   handshake               payload   direction
//   request   start / busy            i_req     in
//   result    o_done (one cycle)      o_res     out
//
// a request whose width is zero or not below the page width is answered from the check;
// otherwise each page tried takes two sweeps of the column store, and a placement a write-back
// of width columns; the single read port of the column store reads one column per cycle
// reset: a clearing pass over all NUM_PAGES * PAGE_WIDTH columns with busy high
// the result beat is shown for one cycle and cannot be stalled

module atlas_skyline_block_allocator #(
    parameter int PAGE_WIDTH  = 128,
    parameter int PAGE_HEIGHT = 128,
    parameter int NUM_PAGES   = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  asba_pkg::t_req i_req,
    output logic           busy,
    output logic           o_done,
    output asba_pkg::t_res o_res
);
    import asba_pkg::*;

    t_cmd cmd;
    t_sts sts;

    asba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy),
        .o_done  (o_done)
    );

    asba_dpath #(
        .PAGE_WIDTH  (PAGE_WIDTH),
        .PAGE_HEIGHT (PAGE_HEIGHT),
        .NUM_PAGES   (NUM_PAGES)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_res   (o_res)
    );

endmodule
